@@ rtl/ppm_p6_stream_to_rgba_core_defines.svh @@
// assertion macros shared by the ppm stream parser rtl
// no dependencies; taken in by `include where assertions are written
`ifndef PPM_P6_STREAM_TO_RGBA_CORE_DEFINES_SVH
`define PPM_P6_STREAM_TO_RGBA_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ppm_pkg.sv @@
// types and constants for the ppm p6 byte stream parser
// no dependencies; imported by every module of the block
package ppm_pkg;

   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_SIX  = 8'h36;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam int PIX_BYTES = 3;

   typedef enum logic [3:0] {
      PH_MAGIC0, PH_MAGIC1, PH_W_SEEK, PH_W_DIG, PH_H_SEEK, PH_H_DIG,
      PH_M_SEEK, PH_M_DIG, PH_PIXELS, PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_PIXEL     = 2'd1,
      KIND_BAD_MAGIC = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] maxv;
      logic [31:0] rgba;
      logic        last;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // decimal accumulate with saturation at 65535
   function automatic logic [15:0] max_acc(input logic [15:0] acc, input logic [3:0] digit);
      logic [19:0] wide;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, digit};
      if (wide > 20'h0FFFF) return 16'hFFFF;
      return wide[15:0];
   endfunction

endpackage

@@ rtl/ppm_parse.sv @@
// input register, header/pixel parse state machine and result formation
// depends on ppm_pkg and ppm_p6_stream_to_rgba_core_defines.svh
`include "ppm_p6_stream_to_rgba_core_defines.svh"

module ppm_parse import ppm_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_sof,
   input  logic       out_space,
   output logic       out_push,
   output result_type out_result
);

   localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};

   // input stage
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_sof_ff;
   logic       fire;

   // parse state
   phase_type             phase_ff, phase_in, s_phase;
   logic                  comment_ff, comment_in, s_comment;
   logic                  first_ok_ff, first_ok_in, s_first_ok;
   logic [DIM_BITS-1:0]   width_ff, width_in, s_width;
   logic [DIM_BITS-1:0]   height_ff, height_in, s_height;
   logic [15:0]           maxv_ff, maxv_in, s_maxv;
   logic [1:0]            bip_ff, bip_in, s_bip;
   logic [7:0]            red_ff, red_in;
   logic [7:0]            green_ff, green_in;
   logic [DIM_BITS-1:0]   col_ff, col_in, s_col;
   logic [DIM_BITS-1:0]   row_ff, row_in, s_row;

   logic       b_digit;
   logic       seek_start;
   logic       seek_comment;
   logic [3:0] digit;
   logic       col_end;
   logic       row_end;

   function automatic logic [DIM_BITS-1:0] dim_acc(input logic [DIM_BITS-1:0] acc,
                                                   input logic [3:0] dig);
      logic [DIM_BITS+3:0] wide;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{DIM_BITS{1'b0}}, dig};
      if (wide > {4'b0, DIM_MAX}) return DIM_MAX;
      return wide[DIM_BITS-1:0];
   endfunction

   function automatic logic [15:0] low16(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS+15:0] ext;
      ext = {16'b0, v};
      return ext[15:0];
   endfunction

   assign fire     = s1_valid_ff && out_space;
   assign in_ready = !s1_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         s1_byte_ff <= in_byte;
         s1_sof_ff  <= in_sof;
      end
   end

   // a frame start clears everything and the byte counts as the first magic byte
   assign s_phase    = s1_sof_ff ? PH_MAGIC0 : phase_ff;
   assign s_comment  = s1_sof_ff ? 1'b0 : comment_ff;
   assign s_first_ok = s1_sof_ff ? 1'b0 : first_ok_ff;
   assign s_width    = s1_sof_ff ? '0 : width_ff;
   assign s_height   = s1_sof_ff ? '0 : height_ff;
   assign s_maxv     = s1_sof_ff ? '0 : maxv_ff;
   assign s_bip      = s1_sof_ff ? '0 : bip_ff;
   assign s_col      = s1_sof_ff ? '0 : col_ff;
   assign s_row      = s1_sof_ff ? '0 : row_ff;

   assign b_digit      = is_digit(s1_byte_ff);
   assign digit        = s1_byte_ff[3:0];
   assign seek_start   = !s_comment && (s1_byte_ff != CH_HASH) && b_digit;
   assign seek_comment = s_comment ? (s1_byte_ff != CH_LF) : (s1_byte_ff == CH_HASH);
   assign col_end      = (s_col + 1'b1) == s_width;
   assign row_end      = (s_row + 1'b1) == s_height;

   always_comb begin
      phase_in    = s_phase;
      comment_in  = s_comment;
      first_ok_in = s_first_ok;
      width_in    = s_width;
      height_in   = s_height;
      maxv_in     = s_maxv;
      bip_in      = s_bip;
      red_in      = s1_sof_ff ? 8'd0 : red_ff;
      green_in    = s1_sof_ff ? 8'd0 : green_ff;
      col_in      = s_col;
      row_in      = s_row;
      out_push    = 1'b0;
      out_result  = '0;
      unique case (s_phase)
         PH_MAGIC0: begin
            first_ok_in = (s1_byte_ff == CH_P);
            phase_in    = PH_MAGIC1;
         end
         PH_MAGIC1: begin
            if (s_first_ok && (s1_byte_ff == CH_SIX)) begin
               phase_in = PH_W_SEEK;
            end else begin
               out_push        = 1'b1;
               out_result.kind = KIND_BAD_MAGIC;
               phase_in        = PH_IDLE;
            end
         end
         PH_W_SEEK: begin
            comment_in = seek_comment;
            if (seek_start) begin
               width_in = dim_acc('0, digit);
               phase_in = PH_W_DIG;
            end
         end
         PH_W_DIG: begin
            if (b_digit) width_in = dim_acc(s_width, digit);
            else         phase_in = PH_H_SEEK;
         end
         PH_H_SEEK: begin
            comment_in = seek_comment;
            if (seek_start) begin
               height_in = dim_acc('0, digit);
               phase_in  = PH_H_DIG;
            end
         end
         PH_H_DIG: begin
            if (b_digit) height_in = dim_acc(s_height, digit);
            else         phase_in  = PH_M_SEEK;
         end
         PH_M_SEEK: begin
            comment_in = seek_comment;
            if (seek_start) begin
               maxv_in  = max_acc(16'd0, digit);
               phase_in = PH_M_DIG;
            end
         end
         PH_M_DIG: begin
            if (b_digit) begin
               maxv_in = max_acc(s_maxv, digit);
            end else begin
               out_push          = 1'b1;
               out_result.kind   = KIND_HEADER;
               out_result.width  = low16(s_width);
               out_result.height = low16(s_height);
               out_result.maxv   = s_maxv;
               bip_in            = '0;
               col_in            = '0;
               row_in            = '0;
               phase_in = ((s_width == '0) || (s_height == '0)) ? PH_IDLE : PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            if (s_bip == 2'd0) begin
               red_in = s1_byte_ff;
               bip_in = 2'd1;
            end else if (s_bip == 2'd1) begin
               green_in = s1_byte_ff;
               bip_in   = 2'd2;
            end else begin
               out_push        = 1'b1;
               out_result.kind = KIND_PIXEL;
               out_result.rgba = {8'd0, s1_byte_ff, green_in, red_in};
               out_result.last = col_end && row_end;
               bip_in          = '0;
               if (col_end && row_end) begin
                  phase_in = PH_IDLE;
               end else if (col_end) begin
                  col_in = '0;
                  row_in = s_row + 1'b1;
               end else begin
                  col_in = s_col + 1'b1;
               end
            end
         end
         PH_IDLE: begin
         end
         default: phase_in = PH_IDLE;
      endcase
      if (!fire) out_push = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC0;
         comment_ff  <= 1'b0;
         first_ok_ff <= 1'b0;
         width_ff    <= '0;
         height_ff   <= '0;
         maxv_ff     <= '0;
         bip_ff      <= '0;
         red_ff      <= '0;
         green_ff    <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         comment_ff  <= comment_in;
         first_ok_ff <= first_ok_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         maxv_ff     <= maxv_in;
         bip_ff      <= bip_in;
         red_ff      <= red_in;
         green_ff    <= green_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   `PPM_ASSERT_NOW(a_pixel_from_pixels, clock, reset,
      out_push && (out_result.kind == KIND_PIXEL), s_phase == PH_PIXELS,
      "pixel item outside the raster phase")
   `PPM_ASSERT_NOW(a_bad_magic_second_byte, clock, reset,
      out_push && (out_result.kind == KIND_BAD_MAGIC), s_phase == PH_MAGIC1,
      "bad magic reported away from the second byte")
   `PPM_ASSERT_NEXT(a_last_goes_idle, clock, reset,
      out_push && out_result.last, phase_ff == PH_IDLE,
      "parser did not stop after the last pixel")

endmodule

@@ rtl/ppm_outbuf.sv @@
// two-entry result buffer (output register plus skid) between parser and result port
// depends on ppm_pkg and ppm_p6_stream_to_rgba_core_defines.svh
`include "ppm_p6_stream_to_rgba_core_defines.svh"

module ppm_outbuf import ppm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff;
   result_type main_ff;
   logic       skid_valid_ff;
   result_type skid_ff;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff       <= push_data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= push_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   `PPM_ASSERT_NOW(a_skid_needs_main, clock, reset,
      skid_valid_ff, main_valid_ff, "skid entry held while output register empty")
   `PPM_ASSERT_NOW(a_no_push_when_full, clock, reset,
      push, !skid_valid_ff, "item pushed into a full result buffer")
   `PPM_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      push && main_valid_ff && !pop, skid_valid_ff, "stalled item not kept in skid")

endmodule

@@ rtl/ppm_p6_stream_to_rgba_core.sv @@
// ppm p6 byte stream to rgba pixel parser, top level
// depends on ppm_pkg, ppm_parse and ppm_outbuf
//
// Takes a binary PPM (P6) file on the req stream, one byte per transfer; req_tuser marks
// the first byte of a file and restarts parsing. After the "P6" magic and the width,
// height and max value fields (separators and '#' comments skipped), one header item
// comes out, then one pixel item per three raster bytes, alpha zero, with rsp_tlast on
// the final pixel. A wrong magic gives one bad-magic item. Throughput is one byte
// every cycle while the result buffer has space; a byte accepted into the input register
// is parsed combinationally and its result is pushed into the result buffer.
// A two-entry result buffer absorbs rsp stalls, and req_tready depends on registers only.
module ppm_p6_stream_to_rgba_core import ppm_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [15:0] image_width, [31:16] image_height,
                                    // [47:32] max_value, [79:48] pixel_rgba
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // last_pixel
);

   logic       space;
   logic       push;
   result_type push_data;
   result_type out_data;

   ppm_parse #(.DIM_BITS(DIM_BITS)) u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_sof     (req_tuser[0]),
      .out_space  (space),
      .out_push   (push),
      .out_result (push_data)
   );

   ppm_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {out_data.rgba, out_data.maxv, out_data.height, out_data.width};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

endmodule

@@ dv/tb_ppm_p6_stream_to_rgba_core.sv @@
// self-checking testbench for ppm_p6_stream_to_rgba_core
// depends on ppm_pkg and the core rtl; builds a byte stream of ppm files, predicts every item
`timescale 1ns / 100ps

module tb_ppm_p6_stream_to_rgba_core;
   import ppm_pkg::*;

   localparam int unsigned DIM_SAT     = 65535;
   localparam int          ITEM_TARGET = 1550;
   localparam int          QUIET_TAIL  = 200;
   localparam int          DRAIN_WAIT  = 20;
   localparam int          CYCLE_LIMIT = 300000;

   typedef struct {
      logic [7:0] value;
      logic       first;
   } stream_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic [0:0]  req_tuser = 1'b0;    // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;          // [15:0] width, [31:16] height, [47:32] max, [79:48] rgba
   logic [1:0]  rsp_tuser;          // [1:0] result_kind
   logic        rsp_tlast;

   stream_item_type pending_items[$];
   logic [7:0] file_bytes[$];
   result_type expected_results[$];

   logic req_fire = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   file_count = 0;
   int   header_seen = 0;
   int   pixel_seen = 0;
   int   bad_magic_seen = 0;

   // parser shadow state
   phase_type   phase;
   bit          in_comment;
   bit          p_seen;
   int unsigned width_acc;
   int unsigned height_acc;
   int unsigned maxval_acc;
   int unsigned pix_slot;
   logic [7:0]  red_hold;
   logic [7:0]  green_hold;
   int unsigned col;
   int unsigned row;

   ppm_p6_stream_to_rgba_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic bit dec_char(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic int unsigned dec_step(input int unsigned acc, input logic [7:0] ch);
      int unsigned v;
      v = acc * 10 + (ch - CH_ZERO);
      return (v > DIM_SAT) ? DIM_SAT : v;
   endfunction

   // true when a field starts on this byte; tracks comment skipping
   function automatic bit field_begins(input logic [7:0] ch);
      if (in_comment) begin
         if (ch == CH_LF) in_comment = 1'b0;
         return 1'b0;
      end
      if (ch == CH_HASH) begin
         in_comment = 1'b1;
         return 1'b0;
      end
      return dec_char(ch);
   endfunction

   task automatic clear_parser();
      phase = PH_MAGIC0;
      in_comment = 1'b0;
      p_seen = 1'b0;
      width_acc = 0;
      height_acc = 0;
      maxval_acc = 0;
      pix_slot = 0;
      red_hold = 8'h00;
      green_hold = 8'h00;
      col = 0;
      row = 0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic start);
      result_type res;
      bit emit;
      bit last;
      res = '0;
      emit = 1'b0;
      if (start) clear_parser();
      case (phase)
         PH_MAGIC0: begin
            p_seen = (b == CH_P);
            phase = PH_MAGIC1;
         end
         PH_MAGIC1: begin
            if (p_seen && b == CH_SIX) begin
               phase = PH_W_SEEK;
            end else begin
               res.kind = KIND_BAD_MAGIC;
               emit = 1'b1;
               phase = PH_IDLE;
            end
         end
         PH_W_SEEK: begin
            if (field_begins(b)) begin
               width_acc = dec_step(0, b);
               phase = PH_W_DIG;
            end
         end
         PH_W_DIG: begin
            if (dec_char(b)) width_acc = dec_step(width_acc, b);
            else phase = PH_H_SEEK;
         end
         PH_H_SEEK: begin
            if (field_begins(b)) begin
               height_acc = dec_step(0, b);
               phase = PH_H_DIG;
            end
         end
         PH_H_DIG: begin
            if (dec_char(b)) height_acc = dec_step(height_acc, b);
            else phase = PH_M_SEEK;
         end
         PH_M_SEEK: begin
            if (field_begins(b)) begin
               maxval_acc = dec_step(0, b);
               phase = PH_M_DIG;
            end
         end
         PH_M_DIG: begin
            if (dec_char(b)) begin
               maxval_acc = dec_step(maxval_acc, b);
            end else begin
               res.kind = KIND_HEADER;
               res.width = width_acc[15:0];
               res.height = height_acc[15:0];
               res.maxv = maxval_acc[15:0];
               emit = 1'b1;
               pix_slot = 0;
               col = 0;
               row = 0;
               phase = (width_acc == 0 || height_acc == 0) ? PH_IDLE : PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            if (pix_slot == 0) begin
               red_hold = b;
               pix_slot = 1;
            end else if (pix_slot == 1) begin
               green_hold = b;
               pix_slot = 2;
            end else begin
               last = (col + 1 == width_acc) && (row + 1 == height_acc);
               res.kind = KIND_PIXEL;
               res.rgba = {8'h00, b, green_hold, red_hold};
               res.last = last;
               emit = 1'b1;
               pix_slot = 0;
               if (last) begin
                  phase = PH_IDLE;
               end else if (col + 1 >= width_acc) begin
                  col = 0;
                  row = (row + 1) & DIM_SAT;
               end else begin
                  col = (col + 1) & DIM_SAT;
               end
            end
         end
         default: phase = PH_IDLE;
      endcase
      if (emit) expected_results.push_back(res);
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic logic [7:0] filler_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (dec_char(c) || c == CH_HASH);
      return c;
   endfunction

   task automatic flush_file(input bit with_start);
      stream_item_type it;
      for (int i = 0; i < file_bytes.size(); i++) begin
         it.value = file_bytes[i];
         it.first = with_start && (i == 0);
         pending_items.push_back(it);
      end
      file_bytes.delete();
      file_count++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
   endtask

   // separators and comments between header fields
   task automatic add_gap(input int lo, input int hi);
      logic [7:0] c;
      repeat ($urandom_range(hi, lo)) begin
         case ($urandom_range(0, 5))
            0: file_bytes.push_back(8'h20);
            1: file_bytes.push_back(CH_LF);
            2: file_bytes.push_back(8'h09);
            3: file_bytes.push_back(8'h0D);
            4: file_bytes.push_back(filler_byte());
            default: begin
               file_bytes.push_back(CH_HASH);
               repeat ($urandom_range(0, 6)) begin
                  do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                  file_bytes.push_back(c);
               end
               file_bytes.push_back(CH_LF);
            end
         endcase
      end
   endtask

   task automatic add_number(input int unsigned v);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) file_bytes.push_back(CH_ZERO);
      add_text($sformatf("%0d", v));
   endtask

   // a hash right after digits is only a terminator
   task automatic add_end();
      case ($urandom_range(0, 4))
         0: file_bytes.push_back(8'h20);
         1: file_bytes.push_back(CH_LF);
         2: file_bytes.push_back(CH_HASH);
         3: file_bytes.push_back(filler_byte());
         default: file_bytes.push_back(8'h09);
      endcase
   endtask

   task automatic gen_file();
      int unsigned sel;
      int unsigned w;
      int unsigned h;
      int unsigned mx;
      int unsigned npix;
      logic [7:0] c;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         case ($urandom_range(0, 2))
            0: begin
               file_bytes.push_back(CH_P);
               do c = 8'($urandom_range(0, 255)); while (c == CH_SIX);
               file_bytes.push_back(c);
            end
            1: begin
               do c = 8'($urandom_range(0, 255)); while (c == CH_P);
               file_bytes.push_back(c);
               file_bytes.push_back(CH_SIX);
            end
            default: begin
               do c = 8'($urandom_range(0, 255)); while (c == CH_P);
               file_bytes.push_back(c);
               file_bytes.push_back(8'($urandom_range(0, 255)));
            end
         endcase
         repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 12) begin
         repeat ($urandom_range(2, 16)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 4);
         npix = 0;
         sel = $urandom_range(0, 99);
         if (sel < 4) w = 0;
         else if (sel < 8) h = 0;
         else if (sel < 12) w = $urandom_range(300, 250000);
         else if (sel < 15) h = $urandom_range(300, 250000);
         mx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99999) : 255;
         // huge images are cut short, the next file start ends them
         if (sel >= 8 && sel < 15) npix = $urandom_range(0, 8);
         else npix = w * h;
         file_bytes.push_back(CH_P);
         file_bytes.push_back(CH_SIX);
         add_gap(0, 2);
         add_number(w);
         add_end();
         add_gap(0, 2);
         add_number(h);
         add_end();
         add_gap(0, 2);
         add_number(mx);
         add_end();
         repeat (npix * PIX_BYTES) begin
            case ($urandom_range(0, 9))
               0: file_bytes.push_back(8'h00);
               1: file_bytes.push_back(8'hFF);
               default: file_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end
      // broken files: a new file start lands anywhere
      if ($urandom_range(0, 99) < 8 && file_bytes.size() > 1) begin
         npix = $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > npix) void'(file_bytes.pop_back());
      end
      flush_file(1'b1);
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_fire) void'(pending_items.pop_front());
         if (req_tvalid && !req_fire) begin
            // hold the item until it is taken
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > QUIET_TAIL &&
                      $urandom_range(0, 99) < req_idle_pct) begin
            req_gap <= $urandom_range(0, 11);
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_items[0].value;
            req_tuser <= pending_items[0].first;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (pending_items.size() > QUIET_TAIL &&
                   $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_gap <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic report_mismatch(input string what, input result_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected kind %0d w %0d h %0d max %0d rgba %h last %0b", $time,
                  what, want.kind, want.width, want.height, want.maxv, want.rgba, want.last);
         $display("%0t %s:   actual kind %0d w %0d h %0d max %0d rgba %h last %0b", $time,
                  what, rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                  rsp_tdata[79:48], rsp_tlast);
      end
   endtask

   always @(posedge clock) begin : check_proc
      result_type want;
      cycle_count = cycle_count + 1;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) parse_byte(req_tdata, req_tuser[0]);
      if (!reset && rsp_tvalid && rsp_tready) begin
         case (rsp_tuser)
            KIND_HEADER: header_seen++;
            KIND_PIXEL: pixel_seen++;
            default: bad_magic_seen++;
         endcase
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[15:0] !== want.width ||
                rsp_tdata[31:16] !== want.height || rsp_tdata[47:32] !== want.maxv ||
                rsp_tdata[79:48] !== want.rgba || rsp_tlast !== want.last)
               report_mismatch("mismatch", want);
         end
      end
      // alternate busy and calm stretches
      if (cycle_count % 256 == 0) begin
         case ($urandom_range(0, 3))
            0: req_idle_pct <= 0;
            1: req_idle_pct <= 4;
            2: req_idle_pct <= 15;
            default: req_idle_pct <= 35;
         endcase
         case ($urandom_range(0, 3))
            0: rsp_idle_pct <= 0;
            1: rsp_idle_pct <= 4;
            2: rsp_idle_pct <= 15;
            default: rsp_idle_pct <= 35;
         endcase
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still expected", cycle_count,
                  expected_results.size());
         $display("ppm_p6_stream_to_rgba_core regression: fail");
         $finish;
      end
   end

   initial begin
      clear_parser();
      // right after reset, no file start flag: comment, hash terminator, max of zero
      add_text("P6#\n1#1 0\n");
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hFF);
      flush_file(1'b0);
      // wrong second magic byte, then an ignored byte
      add_text("P56");
      flush_file(1'b1);
      // zero width, saturated height and max, raster ignored
      add_text("P6 0 99999 099999 ");
      file_bytes.push_back(8'h80);
      flush_file(1'b1);
      while (pending_items.size() < ITEM_TARGET) gen_file();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      mismatches += expected_results.size();

      $display("%0d files streamed; %0d headers, %0d pixels, %0d bad magic items checked",
               file_count, header_seen, pixel_seen, bad_magic_seen);
      $display("%0d cycles, %0d mismatches", cycle_count, mismatches);
      if (mismatches == 0) begin
         $display("ppm_p6_stream_to_rgba_core regression: pass");
      end else begin
         $display("ppm_p6_stream_to_rgba_core regression: fail");
      end
      $finish;
   end

endmodule
